// ----- sv/aesx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package aesx_pkg;
  localparam int BLOCK_BYTES = 16;
  localparam int NUM_LANES = 4;
  localparam int NUM_ROUNDS = 10;
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW = 2'd1;
  localparam logic [1:0] REG_INIT_CTR = 2'd2;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- sv/aesx_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one state column: sub bytes (already shifted) then mix column unless last round
module aesx_lane (
  input  wire logic [31:0] col_in,
  input  wire logic        last_round,
  output logic [31:0]      col_out
);
  logic [7:0] a0, a1, a2, a3, all_x;
  always_comb begin
    a0 = aesx_pkg::sbox(col_in[31:24]);
    a1 = aesx_pkg::sbox(col_in[23:16]);
    a2 = aesx_pkg::sbox(col_in[15:8]);
    a3 = aesx_pkg::sbox(col_in[7:0]);
    all_x = a0 ^ a1 ^ a2 ^ a3;
    if (last_round) begin
      col_out = {a0, a1, a2, a3};
    end else begin
      col_out = {a0 ^ all_x ^ aesx_pkg::xtime(a0 ^ a1),
                 a1 ^ all_x ^ aesx_pkg::xtime(a1 ^ a2),
                 a2 ^ all_x ^ aesx_pkg::xtime(a2 ^ a3),
                 a3 ^ all_x ^ aesx_pkg::xtime(a3 ^ a0)};
    end
  end
endmodule
`default_nettype wire

// ----- sv/aesx_keystep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// next round key from the previous one
module aesx_keystep (
  input  wire logic [127:0] key_in,
  input  wire logic [3:0]   round,
  output logic [127:0]      key_out
);
  logic [31:0] w0, w1, w2, w3, t;
  always_comb begin
    {w0, w1, w2, w3} = key_in;
    t = {aesx_pkg::sbox(w3[23:16]) ^ aesx_pkg::rcon(round), aesx_pkg::sbox(w3[15:8]),
         aesx_pkg::sbox(w3[7:0]), aesx_pkg::sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_out = {w0, w1, w2, w3};
  end
endmodule
`default_nettype wire

// ----- sv/aes128_ctr_xnor_block.sv -----
`timescale 1ns / 1ps
`default_nettype none
// AES-128 counter mode with XNOR combiner.
// in_*: one 128-bit text word per item, tuser = first_block (restarts index).
// out_*: one 128-bit result word per item.
// cfg_*: index 0 key_high, 1 key_low, 2 initial_counter; write only when idle.
// Each item runs through ten rounds on four column lanes, one round per
// cycle while the last round is not held by a full output register, with the
// round key expanded on the fly alongside. The next item is taken only once
// the previous result sits in the output register, so a new word cannot enter
// before the last one is through. A stalled receiver holds the result
// and in_tready stays low until that word is taken. Reset clears key,
// counter base and block index to zero.
module aes128_ctr_xnor_block (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // text_low, text_high
  input  wire logic         in_tuser,   // first_block
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // out_low, out_high
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  logic [127:0] key_r, rk_r, st_r, txt_r, st_nxt, rk_nxt, mix;
  logic [63:0]  ctr_r, idx_r, idx_use, cval;
  logic [3:0]   rnd_r;
  logic         busy_r, done;
  logic [127:0] ks_shift;
  logic [127:0] res;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r && (!out_tvalid || out_tready);
  assign done = busy_r && rnd_r == 4'(aesx_pkg::NUM_ROUNDS) &&
                (!out_tvalid || out_tready);

  // shift rows feeding lanes
  always_comb begin
    for (int c = 0; c < aesx_pkg::NUM_LANES; c++) begin
      for (int k = 0; k < 4; k++) begin
        ks_shift[127 - 32*c - 8*k -: 8] = st_r[127 - 32*((c + k) % 4) - 8*k -: 8];
      end
    end
  end

  for (genvar g = 0; g < aesx_pkg::NUM_LANES; g++) begin : g_lane
    aesx_lane u_lane (
      .col_in(ks_shift[127 - 32*g -: 32]),
      .last_round(rnd_r == 4'(aesx_pkg::NUM_ROUNDS)),
      .col_out(mix[127 - 32*g -: 32])
    );
  end

  aesx_keystep u_key (.key_in(rk_r), .round(rnd_r), .key_out(rk_nxt));

  assign st_nxt = mix ^ rk_nxt;
  assign res = ~(st_nxt ^ txt_r);
  assign idx_use = in_tuser ? 64'd0 : idx_r;
  assign cval = ctr_r + idx_use + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      ctr_r <= '0;
      idx_r <= '0;
      busy_r <= 1'b0;
      out_tvalid <= 1'b0;
      rnd_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          aesx_pkg::REG_KEY_HIGH: key_r[127:64] <= cfg_data;
          aesx_pkg::REG_KEY_LOW: key_r[63:0] <= cfg_data;
          aesx_pkg::REG_INIT_CTR: ctr_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
        rnd_r <= 4'd1;
        idx_r <= idx_use + 64'd1;
        // text_high sits in the low half of tdata
        txt_r <= {in_tdata[63:0], in_tdata[127:64]};
        rk_r <= key_r;
        for (int b = 0; b < 8; b++) st_r[127 - 8*b -: 8] <= cval[8*b +: 8] ^ key_r[127 - 8*b -: 8];
        st_r[63:0] <= key_r[63:0];
      end else if (done) begin
        busy_r <= 1'b0;
        out_tvalid <= 1'b1;
        out_tdata <= {res[63:0], res[127:64]};
      end else if (busy_r && rnd_r != 4'(aesx_pkg::NUM_ROUNDS)) begin
        st_r <= st_nxt;
        rk_r <= rk_nxt;
        rnd_r <= rnd_r + 4'd1;
      end
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r >= 4'd1 && rnd_r <= 4'(aesx_pkg::NUM_ROUNDS)))
    else $error("round out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

// ----- tb/sv/tb_aes128_ctr_xnor_block.sv -----
`timescale 1ns / 1ps
module tb_aes128_ctr_xnor_block;

  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind it

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  aes128_ctr_xnor_block u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [7:0]  sub_tab [256];
  logic [7:0]  rkey [176];
  logic [63:0] key_hi_q, key_lo_q, ctr_base_q, blk_idx_q;
  word_t       pending_words [$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned rcv_hold = 0;
  int unsigned n_sent = 0, n_checked = 0, n_errors = 0, n_first = 0, n_cfg = 0;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  task automatic build_sub_tab();
    logic [7:0] inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (a != 0 && gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[a] = x;
    end
  endtask

  task automatic expand_round_keys();
    logic [7:0] t [4];
    logic [7:0] f;
    for (int i = 0; i < 8; i++) begin
      rkey[i]     = key_hi_q[63 - 8*i -: 8];
      rkey[8 + i] = key_lo_q[63 - 8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rkey[(i-1)*4 + j];
      if ((i % 4) == 0) begin
        f = t[0];
        t[0] = sub_tab[t[1]] ^ (8'h01 << ((i/4) - 1) % 8) ^ ((i/4) > 8 ? 8'h00 : 8'h00);
        if (i/4 == 9) t[0] = sub_tab[t[1]] ^ 8'h1b;
        if (i/4 == 10) t[0] = sub_tab[t[1]] ^ 8'h36;
        t[1] = sub_tab[t[2]];
        t[2] = sub_tab[t[3]];
        t[3] = sub_tab[f];
      end
      for (int j = 0; j < 4; j++) rkey[i*4 + j] = rkey[(i-4)*4 + j] ^ t[j];
    end
  endtask

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // keystream for one counter value, then XNOR with the text
  function automatic word_t ctr_xnor_word(input logic [63:0] ctr, input word_t txt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    word_t r;
    for (int i = 0; i < 16; i++) s[i] = ((i < 8) ? ctr[8*i +: 8] : 8'h00) ^ rkey[i];
    for (int rd = 1; rd <= 10; rd++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) t[c*4 + k] = sub_tab[s[((c + k) % 4)*4 + k]];
      for (int c = 0; c < 4; c++) begin
        if (rd != 10) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ dbl(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ dbl(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ dbl(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[rd*16 + i];
    end
    for (int i = 0; i < 8; i++) begin
      r.hi[63 - 8*i -: 8] = ~(s[i] ^ txt.hi[63 - 8*i -: 8]);
      r.lo[63 - 8*i -: 8] = ~(s[8 + i] ^ txt.lo[63 - 8*i -: 8]);
    end
    return r;
  endfunction

  task automatic predict_word(input word_t txt, input logic first);
    if (first) blk_idx_q = '0;
    pending_words.push_back(ctr_xnor_word(ctr_base_q + blk_idx_q + 64'd1, txt));
    blk_idx_q = blk_idx_q + 64'd1;
  endtask

  // result checker
  always @(posedge clk) begin
    word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hi = out_tdata[63:0];
      got.lo = out_tdata[127:64];
      if (pending_words.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word %h_%h", got.hi, got.lo);
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (got.hi !== want.hi || got.lo !== want.lo) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch word %0d: hi exp %h got %h, lo exp %h got %h",
                     n_checked, want.hi, got.hi, want.lo, got.lo);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rcv_hold > 0) begin
      out_tready <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic first);
    word_t txt;
    txt.hi = hi;
    txt.lo = lo;
    in_tvalid <= 1'b1;
    in_tdata  <= {lo, hi};
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(txt, first);
    n_sent++;
    if (first) n_first++;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      aesx_pkg::REG_KEY_HIGH: begin key_hi_q = val; expand_round_keys(); end
      aesx_pkg::REG_KEY_LOW:  begin key_lo_q = val; expand_round_keys(); end
      aesx_pkg::REG_INIT_CTR: ctr_base_q = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] ic);
    write_reg(aesx_pkg::REG_KEY_HIGH, kh);
    write_reg(aesx_pkg::REG_KEY_LOW, kl);
    write_reg(aesx_pkg::REG_INIT_CTR, ic);
  endtask

  task automatic test_reset_state();
    send_word(64'h0, 64'h0, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
    drain();
  endtask

  task automatic test_directed();
    set_regs(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c, 64'h0);
    send_word(64'h0, 64'h0, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 64'h0, 1'b0);
    send_word(64'h0, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
    drain();
    // counter value wraps past 2^64
    set_regs(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffd);
    for (int i = 0; i < 5; i++) send_word(64'h0, 64'h0, i == 0);
    drain();
    write_reg(REG_SPARE, 64'hdead_beef_dead_beef);
    write_reg(aesx_pkg::REG_INIT_CTR, 64'h8000_0000_0000_0000);
    for (int i = 0; i < 4; i++) send_word($urandom, {$urandom, $urandom}, i == 2);
    drain();
  endtask

  task automatic random_traffic(input int n_words);
    int left;
    int len;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
      for (int i = 0; i < len && left > 0; i++) begin
        // mostly messages with a first block up front, some stray restarts
        send_word({$urandom, $urandom}, {$urandom, $urandom},
                  (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
        left--;
      end
    end
    drain();
  endtask

  task automatic test_random_phases();
    int unsigned idle_set [4] = '{0, 57, 0, 17};
    int unsigned stall_set [4] = '{0, 0, 57, 17};
    for (int p = 0; p < 4; p++) begin
      snd_idle_pct = idle_set[p];
      rcv_stall_pct = stall_set[p];
      set_regs({$urandom, $urandom}, {$urandom, $urandom},
               (p == 3) ? 64'hffff_ffff_ffff_ff00 : {$urandom, $urandom});
      random_traffic(190);
    end
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_regs(64'h0, 64'h0, 64'h0);
    rcv_hold = 300;
    for (int i = 0; i < 12; i++) send_word({$urandom, $urandom}, {$urandom, $urandom}, i == 0);
    drain();
  endtask

  initial begin
    build_sub_tab();
    key_hi_q = '0;
    key_lo_q = '0;
    ctr_base_q = '0;
    blk_idx_q = '0;
    expand_round_keys();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random_phases();
    $display("covered %0d words (%0d message starts), %0d register writes,", n_sent, n_first,
             n_cfg);
    $display("four idle/stall mixes and a long output hold-off; %0d words checked", n_checked);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d words outstanding", n_errors, pending_words.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("timeout");
    $display("FAILURE");
    $finish;
  end
endmodule

// ----- aes128_ctr_xnor_block.f -----
sv/aesx_pkg.sv
sv/aesx_lane.sv
sv/aesx_keystep.sv
sv/aes128_ctr_xnor_block.sv
tb/sv/tb_aes128_ctr_xnor_block.sv
